/* hdl/mnle_pkg.sv */
// Package for the MIDI note to LED strip encoder: field widths, event codes
// and the line coding of one colour byte.
// No dependencies.
`default_nettype none

package mnle_pkg;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CODE_W = 24;
	localparam int unsigned COL_W  = 3;
	localparam int unsigned V_W    = 7;
	localparam int unsigned PROD_W = 22;
	localparam int unsigned RECIP_W = 23;

	// code index of the USB MIDI header
	localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
	localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
	localparam logic [3:0] CIN_CTRL     = 4'hB;

	// status high nibble and channels
	localparam logic [3:0] STAT_OFF  = 4'h8;
	localparam logic [3:0] STAT_ON   = 4'h9;
	localparam logic [3:0] CH_RED    = 4'd0;
	localparam logic [3:0] CH_GREEN  = 4'd1;
	localparam logic [3:0] CH_BLUE   = 4'd2;
	localparam logic [3:0] CH_DARK   = 4'd3;

	// colour bits of one entry
	localparam logic [COL_W-1:0] COL_NONE  = 3'b000;
	localparam logic [COL_W-1:0] COL_RED   = 3'b001;
	localparam logic [COL_W-1:0] COL_GREEN = 3'b010;
	localparam logic [COL_W-1:0] COL_BLUE  = 3'b100;

	localparam logic [BYTE_W-1:0] KEY_BASE   = 8'd21;
	localparam logic [BYTE_W-1:0] LED_TOP    = 8'd88;
	localparam logic [BYTE_W-1:0] CC_VOLUME  = 8'd7;
	localparam logic [V_W-1:0]    V_MAX      = 7'd127;
	localparam logic [BYTE_W-1:0] LEVEL_INIT = 8'd3;
	localparam logic [PROD_W-1:0] LEVEL_DIV  = 22'd16129;

	// ceil(2^36 / 16129): x * LEVEL_RECIP >> 36 equals x / 16129 for x < 2^22
	localparam logic [RECIP_W-1:0] LEVEL_RECIP = 23'd4260617;
	localparam int unsigned        LEVEL_SHIFT = 36;

	localparam logic [2:0] LINE_ONE  = 3'b110;
	localparam logic [2:0] LINE_ZERO = 3'b100;

	// expand a byte to 24 line bits, MSB first
	function automatic logic [CODE_W-1:0] code_byte(input logic [BYTE_W-1:0] v);
		logic [CODE_W-1:0] c;
		for (int i = 0; i < BYTE_W; i++) begin
			c[3*i +: 3] = v[i] ? LINE_ONE : LINE_ZERO;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/mnle_level_calc.sv */
// Brightness calculation: level = floor(255*v*v/16129) for a 7-bit v.
// Squares, scales and then divides by a multiply with the reciprocal, one step a cycle.
// Depends on mnle_pkg.
`default_nettype none

module mnle_level_calc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mnle_pkg::V_W-1:0]      v,
	output logic                               done,
	output logic [mnle_pkg::BYTE_W-1:0]        level
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_SQ,
		C_SCALE,
		C_MUL
	} calc_state_t;

	localparam int unsigned MUL_W = mnle_pkg::PROD_W + mnle_pkg::RECIP_W;

	calc_state_t                        state_q;
	logic                               done_q;
	logic [mnle_pkg::V_W-1:0]           v_q;
	logic [2*mnle_pkg::V_W-1:0]         sq_q;
	logic [mnle_pkg::PROD_W-1:0]        scl_q;
	logic [mnle_pkg::BYTE_W-1:0]        quo_q;

	logic [MUL_W-1:0]                   prod;

	assign prod = {{mnle_pkg::RECIP_W{1'b0}}, scl_q} *
	              {{mnle_pkg::PROD_W{1'b0}}, mnle_pkg::LEVEL_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_SQ;
					end
				end
				C_SQ:    state_q <= C_SCALE;
				C_SCALE: state_q <= C_MUL;
				C_MUL: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE:  v_q  <= v;
			C_SQ:    sq_q <= {{mnle_pkg::V_W{1'b0}}, v_q} * {{mnle_pkg::V_W{1'b0}}, v_q};
			C_SCALE: begin
				// 255*sq as sq*256 - sq
				scl_q <= {sq_q, 8'd0} - {8'd0, sq_q};
			end
			C_MUL:   quo_q <= prod[mnle_pkg::LEVEL_SHIFT +: mnle_pkg::BYTE_W];
			default: ;
		endcase
	end

	assign done  = done_q;
	assign level = quo_q;

endmodule

`default_nettype wire

/* hdl/midi_note_to_led_strip_encoder_unit.sv */
// Turns USB MIDI event packets into coded LED strip updates (index plus
// green, red and blue bytes in 110/100 line code, MSB first). The colour of
// each LED lives in a small synchronous memory with a lit flag per LED that
// reset clears; brightness sits in a register that resets to 3. One packet
// is taken at a time; s_tready is high only while the block is free. A note
// event gives its single result by way of ST_ONE and the output register.
// Key 109 on channel 3 gives LED_COUNT dark results, one a cycle while the
// output is free. Control change 7 squares, scales and multiplies by a
// reciprocal for the new level, then walks the colour memory, skipping
// unlit LEDs and sending lit ones once read, waiting while the output stalls.
// Results sit in an output register, so a new packet can be taken while the
// last one waits on m_tready. Depends on mnle_pkg and mnle_level_calc.
`default_nettype none

module midi_note_to_led_strip_encoder_unit #(
	parameter int unsigned LED_COUNT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// cable_header[7:0], status_byte[15:8], key_byte[23:16], value_byte[31:24]
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// led_index[5:0], code_green[29:6], code_red[53:30], code_blue[77:54], zero[79:78]
	output logic [79:0]      m_tdata,
	output logic             m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_CLR,
		ST_LVL,
		ST_RD,
		ST_EV
	} state_t;

	localparam logic [mnle_pkg::IDX_W-1:0]  LAST_IDX = mnle_pkg::IDX_W'(LED_COUNT - 1);
	localparam logic [mnle_pkg::BYTE_W-1:0] LED_LIM  = mnle_pkg::BYTE_W'(LED_COUNT);

	state_t                              state_q;
	logic [LED_COUNT-1:0]                lit_q;
	logic [mnle_pkg::BYTE_W-1:0]         level_q;
	logic [mnle_pkg::IDX_W-1:0]          idx_q;
	logic [mnle_pkg::IDX_W-1:0]          led_q;
	logic [mnle_pkg::COL_W-1:0]          bits_q;

	logic [mnle_pkg::COL_W-1:0]          mem [0:LED_COUNT-1];
	logic [mnle_pkg::COL_W-1:0]          rd_q;

	logic                                out_valid_q;
	logic                                out_last_q;
	logic [mnle_pkg::IDX_W-1:0]          out_idx_q;
	logic [mnle_pkg::CODE_W-1:0]         out_g_q;
	logic [mnle_pkg::CODE_W-1:0]         out_r_q;
	logic [mnle_pkg::CODE_W-1:0]         out_b_q;

	// packet decode
	logic [3:0]                          cin;
	logic [3:0]                          ch;
	logic [3:0]                          hi;
	logic [mnle_pkg::BYTE_W-1:0]         key;
	logic [mnle_pkg::BYTE_W-1:0]         val;
	logic [mnle_pkg::BYTE_W-1:0]         note;
	logic [mnle_pkg::BYTE_W-1:0]         led8;
	logic                                is_note;
	logic                                is_cc;
	logic                                all_off;
	logic                                darken;
	logic                                light;
	logic                                in_range;
	logic [mnle_pkg::COL_W-1:0]          ch_bits;
	logic [mnle_pkg::V_W-1:0]            v_sat;

	logic                                accept;
	logic                                out_free;
	logic                                out_load;
	logic [mnle_pkg::IDX_W-1:0]          ld_idx;
	logic [mnle_pkg::COL_W-1:0]          ld_col;
	logic [mnle_pkg::BYTE_W-1:0]         ld_level;
	logic                                ld_last;
	logic [LED_COUNT-1:0]                above;
	logic                                lvl_start;
	logic                                lvl_done;
	logic [mnle_pkg::BYTE_W-1:0]         lvl_level;

	assign cin = s_tdata[3:0];
	assign ch  = s_tdata[11:8];
	assign hi  = s_tdata[15:12];
	assign key = s_tdata[23:16];
	assign val = s_tdata[31:24];

	assign note     = key - mnle_pkg::KEY_BASE;
	assign led8     = mnle_pkg::LED_TOP - note;
	assign is_note  = (cin == mnle_pkg::CIN_NOTE_OFF) || (cin == mnle_pkg::CIN_NOTE_ON);
	assign is_cc    = (cin == mnle_pkg::CIN_CTRL) && (key == mnle_pkg::CC_VOLUME);
	assign all_off  = (ch == mnle_pkg::CH_DARK) && (note == mnle_pkg::LED_TOP);
	assign darken   = (ch == mnle_pkg::CH_DARK) || (hi == mnle_pkg::STAT_OFF) ||
	                  (val == '0);
	assign light    = (hi == mnle_pkg::STAT_ON) &&
	                  ((ch == mnle_pkg::CH_RED) || (ch == mnle_pkg::CH_GREEN) ||
	                   (ch == mnle_pkg::CH_BLUE));
	assign in_range = led8 < LED_LIM;
	assign v_sat    = val[mnle_pkg::BYTE_W-1] ? mnle_pkg::V_MAX : val[mnle_pkg::V_W-1:0];

	always_comb begin
		case (ch)
			mnle_pkg::CH_RED:   ch_bits = mnle_pkg::COL_RED;
			mnle_pkg::CH_GREEN: ch_bits = mnle_pkg::COL_GREEN;
			mnle_pkg::CH_BLUE:  ch_bits = mnle_pkg::COL_BLUE;
			default:            ch_bits = mnle_pkg::COL_NONE;
		endcase
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign lvl_start = accept && !is_note && is_cc;

	always_comb begin
		for (int j = 0; j < LED_COUNT; j++) begin
			above[j] = mnle_pkg::IDX_W'(j) > idx_q;
		end
	end

	// what the output register takes this cycle
	always_comb begin
		out_load = 1'b0;
		ld_idx   = idx_q;
		ld_col   = mnle_pkg::COL_NONE;
		ld_level = level_q;
		ld_last  = 1'b0;
		case (state_q)
			ST_ONE: begin
				out_load = out_free;
				ld_idx   = led_q;
				ld_col   = bits_q;
				ld_last  = 1'b1;
			end
			ST_CLR: begin
				out_load = out_free;
				ld_last  = (idx_q == LAST_IDX);
			end
			ST_EV: begin
				out_load = out_free;
				ld_col   = rd_q;
				ld_last  = ~|(lit_q & above);
			end
			default: ;
		endcase
	end

	mnle_level_calc u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lvl_start),
		.v      (v_sat),
		.done   (lvl_done),
		.level  (lvl_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lit_q       <= '0;
			level_q     <= mnle_pkg::LEVEL_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_note) begin
							if (all_off) begin
								lit_q   <= '0;
								state_q <= ST_CLR;
							end else if ((darken || light) && in_range) begin
								state_q <= ST_ONE;
							end
						end else if (is_cc) begin
							state_q <= ST_LVL;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						lit_q[led_q] <= (bits_q != mnle_pkg::COL_NONE) && (level_q != '0);
						state_q      <= ST_IDLE;
					end
				end
				ST_CLR: begin
					if (out_free && idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LVL: begin
					if (lvl_done) begin
						level_q <= lvl_level;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// read of idx_q is in flight; skip unlit entries
					if (lit_q[idx_q]) begin
						state_q <= ST_EV;
					end else if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EV: begin
					if (out_free) begin
						state_q <= (idx_q == LAST_IDX) ? ST_IDLE : ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sweep index and note payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q  <= '0;
				led_q  <= led8[mnle_pkg::IDX_W-1:0];
				bits_q <= darken ? mnle_pkg::COL_NONE : ch_bits;
			end
			ST_CLR: begin
				if (out_free) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_RD: begin
				if (!lit_q[idx_q]) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_EV: begin
				if (out_free) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// colour memory: writes only from a note event; the read at idx_q runs every
	// cycle but is used only in the sweep, so a used read and a write never touch the same entry in overlapping cycles
	always_ff @(posedge clk) begin
		if (state_q == ST_ONE && out_free) begin
			mem[led_q] <= bits_q;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= ld_idx;
			out_last_q <= ld_last;
			out_r_q    <= mnle_pkg::code_byte(ld_col[0] ? ld_level : '0);
			out_g_q    <= mnle_pkg::code_byte(ld_col[1] ? ld_level : '0);
			out_b_q    <= mnle_pkg::code_byte(ld_col[2] ? ld_level : '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_b_q, out_r_q, out_g_q, out_idx_q};

endmodule

`default_nettype wire

/* test/midi_note_to_led_strip_encoder_unit_tb.sv */
// Testbench for midi_note_to_led_strip_encoder_unit: directed and random MIDI
// packets, a behavioral LED-colour predictor and an in-order result checker.
// Depends on mnle_pkg and the encoder RTL.
module midi_note_to_led_strip_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LED_COUNT   = 64;
	localparam int unsigned IDLE_LIMIT  = 3000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned RANDOM_ITEMS = 150;

	// codes that the block must ignore
	localparam logic [3:0] CIN_MISC     = 4'h0;
	localparam logic [3:0] CIN_POLY_AT  = 4'hA;
	localparam logic [3:0] STAT_POLY_AT = 4'hA;
	localparam logic [3:0] STAT_SYSTEM  = 4'hF;
	localparam logic [3:0] CH_FIRST_IGN = 4'd4;
	localparam logic [3:0] CH_LAST_IGN  = 4'd15;
	// status nibble of a control change; the block does not look at it
	localparam logic [3:0] STAT_CTRL    = 4'hB;
	localparam logic [mnle_pkg::BYTE_W-1:0] KEY_ALL_OFF =
		mnle_pkg::KEY_BASE + mnle_pkg::LED_TOP;
	localparam logic [mnle_pkg::BYTE_W-1:0] KEY_LED_LAST = KEY_ALL_OFF - 8'(LED_COUNT - 1);

	typedef struct packed {
		logic [mnle_pkg::IDX_W-1:0]  led;
		logic [mnle_pkg::CODE_W-1:0] green;
		logic [mnle_pkg::CODE_W-1:0] red;
		logic [mnle_pkg::CODE_W-1:0] blue;
		logic                        last;
	} led_update_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tlast;

	logic [31:0]                 midi_packets [$];
	led_update_t                 pending_updates [$];
	logic [mnle_pkg::COL_W-1:0]  led_colours [LED_COUNT] = '{default: mnle_pkg::COL_NONE};
	logic [mnle_pkg::BYTE_W-1:0] brightness = mnle_pkg::LEVEL_INIT;

	int unsigned sent_count = 0;
	int unsigned update_count = 0;
	int unsigned fail_count = 0;
	int unsigned stuck_cycles = 0;

	midi_note_to_led_strip_encoder_unit #(
		.LED_COUNT(LED_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [mnle_pkg::CODE_W-1:0] line_code(
			input logic [mnle_pkg::BYTE_W-1:0] b);
		logic [mnle_pkg::CODE_W-1:0] c;
		int k;
		c = '0;
		for (k = mnle_pkg::BYTE_W - 1; k >= 0; k--) begin
			c = {c[mnle_pkg::CODE_W-4:0], b[k] ? mnle_pkg::LINE_ONE : mnle_pkg::LINE_ZERO};
		end
		return c;
	endfunction

	function automatic void push_update(input int unsigned led,
			input logic [mnle_pkg::COL_W-1:0] colour, input logic last);
		led_update_t u;
		u.led   = mnle_pkg::IDX_W'(led);
		u.green = line_code((colour & mnle_pkg::COL_GREEN) != 0 ? brightness : 8'd0);
		u.red   = line_code((colour & mnle_pkg::COL_RED) != 0 ? brightness : 8'd0);
		u.blue  = line_code((colour & mnle_pkg::COL_BLUE) != 0 ? brightness : 8'd0);
		u.last  = last;
		pending_updates.push_back(u);
	endfunction

	function automatic void apply_midi_packet(input logic [31:0] pkt);
		logic [3:0] cin;
		logic [3:0] stat_hi;
		logic [3:0] chan;
		logic [mnle_pkg::BYTE_W-1:0] key;
		logic [mnle_pkg::BYTE_W-1:0] vel;
		logic [mnle_pkg::BYTE_W-1:0] note;
		logic [mnle_pkg::BYTE_W-1:0] led;
		logic [mnle_pkg::COL_W-1:0] colour;
		logic hit;
		int unsigned v;
		int last_lit;
		int i;
		cin     = pkt[3:0];
		chan    = pkt[11:8];
		stat_hi = pkt[15:12];
		key     = pkt[23:16];
		vel     = pkt[31:24];
		note    = key - mnle_pkg::KEY_BASE;
		led     = mnle_pkg::LED_TOP - note;
		if (cin == mnle_pkg::CIN_NOTE_OFF || cin == mnle_pkg::CIN_NOTE_ON) begin
			if (chan == mnle_pkg::CH_DARK && note == mnle_pkg::LED_TOP) begin
				for (i = 0; i < LED_COUNT; i++) begin
					led_colours[i] = mnle_pkg::COL_NONE;
					push_update(i, mnle_pkg::COL_NONE, i == LED_COUNT - 1);
				end
			end else begin
				hit = 1'b0;
				colour = mnle_pkg::COL_NONE;
				if (chan == mnle_pkg::CH_DARK || stat_hi == mnle_pkg::STAT_OFF ||
						vel == 0) begin
					hit = 1'b1;
				end else if (stat_hi == mnle_pkg::STAT_ON && chan <= mnle_pkg::CH_BLUE) begin
					hit = 1'b1;
					colour = (chan == mnle_pkg::CH_RED) ? mnle_pkg::COL_RED :
						(chan == mnle_pkg::CH_GREEN) ? mnle_pkg::COL_GREEN :
						mnle_pkg::COL_BLUE;
				end
				if (hit && led < LED_COUNT) begin
					// a light at level zero shows dark and leaves no lit entry
					led_colours[led] = (brightness != 0) ? colour : mnle_pkg::COL_NONE;
					push_update(led, colour, 1'b1);
				end
			end
		end else if (cin == mnle_pkg::CIN_CTRL && key == mnle_pkg::CC_VOLUME) begin
			v = (vel > mnle_pkg::V_MAX) ? mnle_pkg::V_MAX : vel;
			brightness = mnle_pkg::BYTE_W'((255 * v * v) / mnle_pkg::LEVEL_DIV);
			last_lit = -1;
			for (i = 0; i < LED_COUNT; i++) begin
				if (led_colours[i] != mnle_pkg::COL_NONE) last_lit = i;
			end
			for (i = 0; i < LED_COUNT; i++) begin
				if (led_colours[i] != mnle_pkg::COL_NONE) begin
					push_update(i, led_colours[i], i == last_lit);
				end
			end
		end
	endfunction

	task automatic queue_packet(input logic [3:0] cin, input logic [7:0] status,
			input logic [7:0] key, input logic [7:0] vel);
		logic [3:0] cable;
		cable = 4'($urandom_range(0, 15));
		midi_packets.push_back({vel, key, status, cable, cin});
	endtask

	task automatic note_mismatch(input string what, input led_update_t want,
			input led_update_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%0t: %s: expected led %0d g %06h r %06h b %06h last %0b",
				$realtime, what, want.led, want.green, want.red, want.blue, want.last);
			$display("    got led %0d g %06h r %06h b %06h last %0b",
				got.led, got.green, got.red, got.blue, got.last);
		end
	endtask

	// feed queued packets, holding each until the block takes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid) begin
					apply_midi_packet(s_tdata);
					sent_count <= sent_count + 1;
				end
				if (midi_packets.size() > 0 &&
						((sent_count >= 90 && sent_count < 130) || $urandom_range(0, 99) >= 20)) begin
					s_tdata  <= midi_packets.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// check each LED update against the oldest prediction
	always @(posedge clk) begin
		static int unsigned hold_left = 0;
		static bit held = 0;
		led_update_t got;
		led_update_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[5:0], m_tdata[29:6], m_tdata[53:30], m_tdata[77:54], m_tlast};
				update_count <= update_count + 1;
				if (pending_updates.size() == 0) begin
					note_mismatch("unexpected update", '0, got);
				end else begin
					want = pending_updates.pop_front();
					if (got !== want) note_mismatch("update mismatch", want, got);
				end
			end
			// one long back-pressure stretch while the sender keeps offering
			if (!held && sent_count >= 60) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (update_count >= 200 && update_count < 320) ||
					$urandom_range(0, 99) >= 20;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int pick;
		logic [3:0] cin;
		logic [3:0] stat_hi;
		logic [3:0] chan;
		logic [7:0] key;
		logic [7:0] vel;

		// light the strip ends and one middle LED in each colour
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_RED},
			KEY_ALL_OFF, 8'd127);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_GREEN},
			KEY_LED_LAST, 8'd1);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_BLUE},
			8'd80, 8'd255);
		// full volume, then a value past the 7-bit range
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME, 8'd127);
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME, 8'd255);
		// note-off code index still carries a note-on status
		queue_packet(mnle_pkg::CIN_NOTE_OFF, {mnle_pkg::STAT_ON, mnle_pkg::CH_RED},
			8'd60, 8'd64);
		queue_packet(mnle_pkg::CIN_NOTE_OFF, {mnle_pkg::STAT_OFF, mnle_pkg::CH_RED},
			8'd60, 8'd64);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_BLUE},
			8'd80, 8'd0);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_DARK},
			KEY_LED_LAST, 8'd90);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, CH_FIRST_IGN}, 8'd70, 8'd90);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, CH_LAST_IGN}, 8'd71, 8'd90);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {STAT_POLY_AT, mnle_pkg::CH_RED}, 8'd72, 8'd5);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {STAT_POLY_AT, mnle_pkg::CH_RED}, 8'd70, 8'd0);
		// keys whose LED index falls off the strip
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_RED},
			KEY_LED_LAST - 8'd1, 8'd40);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_RED},
			mnle_pkg::KEY_BASE, 8'd40);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_GREEN},
			KEY_ALL_OFF + 8'd1, 8'd40);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_BLUE},
			8'd0, 8'd40);
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME + 8'd1, 8'd100);
		queue_packet(CIN_POLY_AT, {STAT_CTRL, mnle_pkg::CH_RED}, mnle_pkg::CC_VOLUME, 8'd100);
		queue_packet(CIN_MISC, {STAT_SYSTEM, CH_LAST_IGN}, 8'hFF, 8'hFF);
		// zero level: re-emit dark, then a light that stores nothing
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME, 8'd0);
		queue_packet(mnle_pkg::CIN_NOTE_ON, {mnle_pkg::STAT_ON, mnle_pkg::CH_GREEN},
			8'd50, 8'd77);
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME, 8'd64);
		queue_packet(mnle_pkg::CIN_NOTE_OFF, {mnle_pkg::STAT_OFF, mnle_pkg::CH_DARK},
			KEY_ALL_OFF, 8'd0);
		queue_packet(mnle_pkg::CIN_CTRL, {STAT_CTRL, mnle_pkg::CH_RED},
			mnle_pkg::CC_VOLUME, 8'd100);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			vel = 8'($urandom_range(0, 255));
			if (pick < 58) begin
				cin = $urandom_range(0, 1) ? mnle_pkg::CIN_NOTE_ON : mnle_pkg::CIN_NOTE_OFF;
				pick = $urandom_range(0, 99);
				stat_hi = (pick < 70) ? mnle_pkg::STAT_ON :
					(pick < 90) ? mnle_pkg::STAT_OFF : 4'($urandom_range(0, 15));
				chan = ($urandom_range(0, 9) < 8) ?
					4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
				key = ($urandom_range(0, 9) < 8) ?
					8'($urandom_range(KEY_LED_LAST, KEY_ALL_OFF)) : 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) == 0) vel = 8'd0;
				queue_packet(cin, {stat_hi, chan}, key, vel);
			end else if (pick < 61) begin
				queue_packet(mnle_pkg::CIN_NOTE_ON, {4'($urandom_range(0, 15)), mnle_pkg::CH_DARK},
					KEY_ALL_OFF, vel);
			end else if (pick < 75) begin
				queue_packet(mnle_pkg::CIN_CTRL, 8'($urandom_range(0, 255)),
					mnle_pkg::CC_VOLUME, vel);
			end else if (pick < 82) begin
				queue_packet(mnle_pkg::CIN_CTRL, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), vel);
			end else begin
				midi_packets.push_back($urandom());
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (midi_packets.size() != 0 || s_tvalid) @(posedge clk);
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_updates.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
